>>> hw/rtl/mhb_pkg.sv
// mhb_pkg: shared types, codes and defaults of the multidimensional histogram binner.
// Used by mhb_edge_search and multidim_histogram_binner; depends on nothing.
`timescale 1ns / 1ps

package mhb_pkg;

  // Parameter defaults
  localparam int MAX_BINS_DEF    = 16;
  localparam int MAX_DIMS_DEF    = 3;
  localparam int COUNT_WIDTH_DEF = 32;
  localparam int VALUE_WIDTH_DEF = 32;

  // Cell address space, fixed by the cell_index field
  localparam int CELL_W     = 12;
  localparam int CELL_DEPTH = 1 << CELL_W;

  // Smallest bin count in use
  localparam int MIN_BINS = 2;

  // Item kinds
  localparam logic [1:0] KIND_EDGE  = 2'd0;
  localparam logic [1:0] KIND_COORD = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // Configuration register indexes
  localparam logic CFG_NUM_BINS = 1'b0;
  localparam logic CFG_NUM_DIMS = 1'b1;

  // Configuration reset values
  localparam logic [4:0] NUM_BINS_RST = 5'd16;
  localparam logic [1:0] NUM_DIMS_RST = 2'd2;

  // Input item
  typedef struct packed {
    logic [1:0]         kind;
    logic [3:0]         edge_index;
    logic signed [31:0] value;
    logic [11:0]        cell_index;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [3:0]  bin_index;
    logic [11:0] point_cell;
    logic        point_done;
    logic [31:0] cell_count;
    logic [31:0] total_count;
  } out_item_t;

  // Commands from the sequencer to the edge search unit
  typedef struct packed {
    logic edge_we;
    logic start;
  } srch_cmd_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SEARCH,
    ST_RMW,
    ST_READ
  } state_t;

endpackage

>>> hw/rtl/mhb_count_mem.sv
// mhb_count_mem: cell counter memory, one write port and one registered read port.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module mhb_count_mem #(
  parameter int WIDTH  = 32,
  parameter int ADDR_W = 12
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/mhb_edge_search.sv
// mhb_edge_search: interior edge table and the binary search that places a coordinate.
// Depends on mhb_pkg for the command struct.
`timescale 1ns / 1ps

module mhb_edge_search
  import mhb_pkg::*;
#(
  parameter int MAX_BINS    = MAX_BINS_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  localparam int BIN_W      = $clog2(MAX_BINS),
  localparam int NB_W       = $clog2(MAX_BINS + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  srch_cmd_t        cmd,
  input  logic [3:0]       edge_idx,
  input  logic [31:0]      value,
  input  logic [NB_W-1:0]  nb,
  output logic             done,
  output logic [BIN_W-1:0] bin
);

  logic [VALUE_WIDTH-1:0] edge_q [1:MAX_BINS-1];
  logic [VALUE_WIDTH-1:0] key_in;
  logic [VALUE_WIDTH-1:0] key_r;
  logic [VALUE_WIDTH-1:0] edge_rd;
  logic [BIN_W-1:0]       lo_r;
  logic [BIN_W-1:0]       hi_r;
  logic [BIN_W:0]         mid_sum;
  logic [BIN_W-1:0]       mid;
  logic [BIN_W-1:0]       probe;
  logic                   active_r;
  logic [6:0]             eidx_ext;
  logic                   eidx_ok;
  logic                   below;

  // Low VALUE_WIDTH bits of the value, compared as signed
  assign key_in = VALUE_WIDTH'($unsigned(value));

  // Edge write, index range checked
  assign eidx_ext = {3'b000, edge_idx};
  assign eidx_ok  = (eidx_ext != 7'd0) && (eidx_ext < 7'(MAX_BINS));

  always_ff @(posedge clk) begin
    if (cmd.edge_we && eidx_ok) begin
      edge_q[eidx_ext[BIN_W-1:0]] <= key_in;
    end
  end

  // Probe the upper edge of the middle bin
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid     = mid_sum[BIN_W:1];
  assign probe   = mid + BIN_W'(1);
  assign edge_rd = edge_q[probe];
  assign below   = $signed(key_r) < $signed(edge_rd);

  // One halving step per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (cmd.start) begin
      active_r <= 1'b1;
    end else if (active_r && !(hi_r > lo_r)) begin
      active_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key_r <= key_in;
      lo_r  <= '0;
      hi_r  <= BIN_W'(nb - NB_W'(1));
    end else if (active_r && (hi_r > lo_r)) begin
      if (below) begin
        hi_r <= mid;
      end else begin
        lo_r <= probe;
      end
    end
  end

  assign done = active_r && !(hi_r > lo_r);
  assign bin  = lo_r;

endmodule

>>> hw/rtl/multidim_histogram_binner.sv
// multidim_histogram_binner: top level, item sequencer, point accumulation and counters.
// Depends on mhb_pkg, mhb_edge_search and mhb_count_mem.
`timescale 1ns / 1ps
//
//  channel  ports                        handshake
//  -------  ---------------------------  ----------------------------------
//  input    start, busy, in_data         taken when start high, busy low
//  result   out_valid, out_data          one-cycle strobe, cannot be held
//  config   cfg_we, cfg_index, cfg_wdata write when cfg_we high, no wait
//
//  Edge writes and unknown kinds never raise busy; a cell read passes through ST_READ.
//  A coordinate passes through ST_SEARCH for S binary search steps, where S is at
//  most ceil(log2(num_bins)), one step per cycle, and also through ST_RMW when it
//  completes a point; ST_RMW is the read-modify-write of the counter memory.
//  After reset a clearing pass zeroes all 4096 counters with busy high;
//  configuration writes are taken during it. Results are never stalled.

module multidim_histogram_binner
  import mhb_pkg::*;
#(
  parameter int MAX_BINS    = MAX_BINS_DEF,
  parameter int MAX_DIMS    = MAX_DIMS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_valid,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic      cfg_index,
  input  logic [4:0] cfg_wdata
);

  localparam int BIN_W = $clog2(MAX_BINS);
  localparam int NB_W  = $clog2(MAX_BINS + 1);
  localparam int PW    = CELL_W + NB_W;

  state_t                 state_r, state_nxt;
  logic [4:0]             num_bins_r;
  logic [1:0]             num_dims_r;
  logic [1:0]             coord_r, coord_nxt;
  logic [CELL_W-1:0]      partial_r, partial_nxt;
  logic [CELL_W-1:0]      cell_r, cell_nxt;
  logic [BIN_W-1:0]       bin_r, bin_nxt;
  logic [COUNT_WIDTH-1:0] total_r, total_nxt, total_inc;
  logic [CELL_W-1:0]      clr_r, clr_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_item_r, out_item_nxt;

  logic                   accept;
  srch_cmd_t              srch_cmd;
  logic                   srch_done;
  logic [BIN_W-1:0]       srch_bin;
  logic [6:0]             nb_raw, nb_clamp;
  logic [NB_W-1:0]        nb;
  logic [2:0]             dims_raw, dims;
  logic                   last_coord;
  logic [PW-1:0]          cell_wide;
  logic [CELL_W-1:0]      cell_calc;

  logic                   mem_we;
  logic [CELL_W-1:0]      mem_waddr;
  logic [COUNT_WIDTH-1:0] mem_wdata;
  logic [CELL_W-1:0]      mem_raddr;
  logic [COUNT_WIDTH-1:0] mem_rdata;
  logic [COUNT_WIDTH-1:0] cnt_inc;

  assign accept = start && !busy;

  // Bins and dimensions in use, clamped to their legal range
  assign nb_raw   = {2'b00, num_bins_r};
  assign nb_clamp = (nb_raw < 7'(MIN_BINS)) ? 7'(MIN_BINS) :
                    (nb_raw > 7'(MAX_BINS)) ? 7'(MAX_BINS) : nb_raw;
  assign nb       = nb_clamp[NB_W-1:0];

  assign dims_raw = {1'b0, num_dims_r};
  assign dims     = (dims_raw == 3'd0)       ? 3'd1 :
                    (dims_raw > 3'(MAX_DIMS)) ? 3'(MAX_DIMS) : dims_raw;
  assign last_coord = (({1'b0, coord_r} + 3'd1) >= dims);

  // Row-major cell, wraps to the cell width
  assign cell_wide = PW'(partial_r) * PW'(nb) + PW'(srch_bin);
  assign cell_calc = cell_wide[CELL_W-1:0];

  // Saturating increments
  assign cnt_inc   = (mem_rdata == '1) ? mem_rdata : mem_rdata + COUNT_WIDTH'(1);
  assign total_inc = (total_r == '1) ? total_r : total_r + COUNT_WIDTH'(1);

  // Edge table and search
  mhb_edge_search #(
    .MAX_BINS    (MAX_BINS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_search (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (srch_cmd),
    .edge_idx (in_data.edge_index),
    .value    (in_data.value),
    .nb       (nb),
    .done     (srch_done),
    .bin      (srch_bin)
  );

  // Cell counters
  mhb_count_mem #(
    .WIDTH  (COUNT_WIDTH),
    .ADDR_W (CELL_W)
  ) u_counts (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_data.kind)
            KIND_COORD: state_nxt = ST_SEARCH;
            KIND_READ:  state_nxt = ST_READ;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SEARCH: begin
        if (srch_done) begin
          state_nxt = last_coord ? ST_RMW : ST_IDLE;
        end
      end
      ST_RMW:  state_nxt = ST_IDLE;
      ST_READ: state_nxt = ST_IDLE;
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // Control outputs
  always_comb begin
    busy             = (state_r != ST_IDLE);
    srch_cmd.start   = (state_r == ST_IDLE) && start && (in_data.kind == KIND_COORD);
    srch_cmd.edge_we = (state_r == ST_IDLE) && start && (in_data.kind == KIND_EDGE);
    mem_raddr        = (state_r == ST_SEARCH) ? cell_calc : in_data.cell_index;
    mem_we           = (state_r == ST_CLEAR) || (state_r == ST_RMW);
    mem_waddr        = (state_r == ST_CLEAR) ? clr_r : cell_r;
    mem_wdata        = (state_r == ST_CLEAR) ? '0 : cnt_inc;
  end

  // Point accumulation and result assembly
  always_comb begin
    coord_nxt     = coord_r;
    partial_nxt   = partial_r;
    cell_nxt      = cell_r;
    bin_nxt       = bin_r;
    total_nxt     = total_r;
    clr_nxt       = clr_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + CELL_W'(1);
      end
      ST_IDLE: begin
        // edge writes and unknown kinds answer at once
        if (accept && (in_data.kind != KIND_COORD) && (in_data.kind != KIND_READ)) begin
          out_valid_nxt            = 1'b1;
          out_item_nxt.bin_index   = '0;
          out_item_nxt.point_cell  = '0;
          out_item_nxt.point_done  = 1'b0;
          out_item_nxt.cell_count  = '0;
          out_item_nxt.total_count = 32'(total_r);
        end
      end
      ST_SEARCH: begin
        if (srch_done) begin
          if (last_coord) begin
            cell_nxt    = cell_calc;
            bin_nxt     = srch_bin;
            coord_nxt   = '0;
            partial_nxt = '0;
          end else begin
            coord_nxt                = coord_r + 2'd1;
            partial_nxt              = cell_calc;
            out_valid_nxt            = 1'b1;
            out_item_nxt.bin_index   = 4'(srch_bin);
            out_item_nxt.point_cell  = '0;
            out_item_nxt.point_done  = 1'b0;
            out_item_nxt.cell_count  = '0;
            out_item_nxt.total_count = 32'(total_r);
          end
        end
      end
      ST_RMW: begin
        total_nxt                = total_inc;
        out_valid_nxt            = 1'b1;
        out_item_nxt.bin_index   = 4'(bin_r);
        out_item_nxt.point_cell  = cell_r;
        out_item_nxt.point_done  = 1'b1;
        out_item_nxt.cell_count  = 32'(cnt_inc);
        out_item_nxt.total_count = 32'(total_inc);
      end
      ST_READ: begin
        out_valid_nxt            = 1'b1;
        out_item_nxt.bin_index   = '0;
        out_item_nxt.point_cell  = '0;
        out_item_nxt.point_done  = 1'b0;
        out_item_nxt.cell_count  = 32'(mem_rdata);
        out_item_nxt.total_count = 32'(total_r);
      end
      default: begin
        clr_nxt = '0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      coord_r     <= '0;
      partial_r   <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      coord_r     <= coord_nxt;
      partial_r   <= partial_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_bins_r <= NUM_BINS_RST;
      num_dims_r <= NUM_DIMS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NUM_BINS: num_bins_r <= cfg_wdata;
        CFG_NUM_DIMS: num_dims_r <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cell_r     <= cell_nxt;
    bin_r      <= bin_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // A coordinate item always enters the search
  a_coord_search: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_data.kind == KIND_COORD)) |=> (state_r == ST_SEARCH))
    else $error("coordinate item did not start a search");

  // The counter update always yields a completed point result
  a_rmw_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RMW) |=> (out_valid_r && out_item_r.point_done))
    else $error("counter update gave no completed result");

  // A completed point comes only from the counter update
  a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.point_done) |-> ($past(state_r) == ST_RMW))
    else $error("point completed outside the counter update");

  // A completed point never reports an empty total
  a_done_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.point_done) |->
      ((out_item_r.total_count != '0) || (COUNT_WIDTH > 32)))
    else $error("completed point with zero total");

  // No item is taken during the clearing pass
  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> busy)
    else $error("item accepted during clearing pass");

endmodule

>>> bench/multidim_histogram_binner_tb.sv
// multidim_histogram_binner_tb: self-checking bench for the histogram binner.
// Edge, coordinate and read items are checked against a behavioural copy of the bins
// and counters. Depends on mhb_pkg and multidim_histogram_binner.
`timescale 1ns / 1ps

module multidim_histogram_binner_tb;
  import mhb_pkg::*;

  localparam int IDLE_LIMIT = 20000;  // clearing pass plus generous margin
  localparam int SETTLE_CYC = 16;
  localparam int MAX_SHOWN  = 40;
  localparam int N_PHASES   = 13;
  localparam logic [1:0] KIND_NONE = 2'd3;

  typedef enum {IDLE_NONE, IDLE_SOME, IDLE_FULL} idle_t;
  typedef enum {EDGES_NARROW, EDGES_WIDE, EDGES_SHUFFLED} edge_shape_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  in_item_t   in_data = '0;
  logic       out_valid;
  out_item_t  out_data;
  logic       cfg_we = 1'b0;
  logic       cfg_index = CFG_NUM_BINS;
  logic [4:0] cfg_wdata = '0;

  multidim_histogram_binner uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  // Items waiting to be driven, and results still owed by the block
  in_item_t  pending_items [$];
  out_item_t owed_results [$];

  int    n_errors = 0;
  int    hold_off = 0;
  int    stalled  = 0;
  idle_t idle_mode = IDLE_NONE;

  // Mirror of the block's state and registers
  logic signed [31:0] edge_mirror [0:15];
  logic [31:0]        tally [0:CELL_DEPTH-1];
  logic [31:0]        points_seen;
  logic [1:0]         coords_held;
  logic [11:0]        cell_so_far;
  logic [4:0]         bins_reg;
  logic [1:0]         dims_reg;

  // Stimulus-side view of the edges and the effective settings
  logic signed [31:0] plan_edge [1:15];
  int unsigned        plan_bins;
  int unsigned        plan_dims;

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    n_errors++;
    if (n_errors <= MAX_SHOWN)
      $display("mismatch at %0t: %s got %0h want %0h", $time, field, got, want);
  endtask

  function automatic logic [31:0] bump(input logic [31:0] c);
    return (&c) ? c : c + 32'd1;
  endfunction

  // Binary search over the interior edges; lands on the top bin at or above the last
  function automatic int unsigned search_bin(input logic signed [31:0] v, input int unsigned nb);
    int unsigned lo, hi, mid;
    lo = 0;
    hi = nb - 1;
    mid = hi / 2;
    while (hi > lo) begin
      if (v < edge_mirror[(mid + 1) % MAX_BINS_DEF]) hi = mid;
      else lo = mid + 1;
      mid = (lo + hi) / 2;
    end
    return lo;
  endfunction

  // Applies one item to the mirror and yields the result it should produce
  task automatic bin_and_count(input in_item_t it, output out_item_t res);
    int unsigned nb, nd, b, cell_idx;
    res = '0;
    nb = (bins_reg < MIN_BINS) ? MIN_BINS : (bins_reg > MAX_BINS_DEF) ? MAX_BINS_DEF : bins_reg;
    nd = (dims_reg == 0) ? 1 : (dims_reg > MAX_DIMS_DEF) ? MAX_DIMS_DEF : dims_reg;
    case (it.kind)
      KIND_EDGE: begin
        if (it.edge_index != 0) edge_mirror[it.edge_index] = $signed(it.value);
      end
      KIND_COORD: begin
        b = search_bin($signed(it.value), nb);
        cell_idx = (cell_so_far * nb + b) % CELL_DEPTH;
        res.bin_index = b[3:0];
        if (coords_held + 1 >= nd) begin
          tally[cell_idx] = bump(tally[cell_idx]);
          points_seen = bump(points_seen);
          res.point_cell = cell_idx[11:0];
          res.point_done = 1'b1;
          res.cell_count = tally[cell_idx];
          coords_held = '0;
          cell_so_far = '0;
        end else begin
          coords_held = coords_held + 2'd1;
          cell_so_far = cell_idx[11:0];
        end
      end
      KIND_READ: res.cell_count = tally[it.cell_index];
      default: ;
    endcase
    res.total_count = points_seen;
  endtask

  function automatic int unsigned draw_gap();
    case (idle_mode)
      IDLE_NONE: return 0;
      IDLE_SOME: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
      default:   return $urandom_range(0, 16);
    endcase
  endfunction

  // Driver: presents items from the queue, predicts each one as it is taken
  always @(posedge clk) begin : drive
    out_item_t   want;
    int unsigned gap;
    if (!rst_n) begin
      start <= 1'b0;
      hold_off <= 0;
      bins_reg = NUM_BINS_RST;
      dims_reg = NUM_DIMS_RST;
      points_seen = '0;
      coords_held = '0;
      cell_so_far = '0;
      for (int i = 0; i < CELL_DEPTH; i++) tally[i] = '0;
      for (int i = 0; i < 16; i++) edge_mirror[i] = '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_NUM_BINS) bins_reg = cfg_wdata;
        else dims_reg = cfg_wdata[1:0];
      end
      if (start && !busy) begin
        bin_and_count(in_data, want);
        owed_results.push_back(want);
        gap = draw_gap();
        // back-to-back: start stays high, only the payload moves on
        if (gap == 0 && pending_items.size() != 0) begin
          in_data <= pending_items.pop_front();
        end else begin
          start <= 1'b0;
          hold_off <= gap;
        end
      end else if (!start) begin
        if (hold_off != 0) begin
          hold_off <= hold_off - 1;
        end else if (pending_items.size() != 0) begin
          in_data <= pending_items.pop_front();
          start <= 1'b1;
        end
      end
    end
  end

  // Monitor: every strobe must match the oldest owed result
  always @(posedge clk) begin : check
    out_item_t want;
    if (rst_n && out_valid) begin
      if (owed_results.size() == 0) begin
        report_mismatch("result with no item outstanding", out_data.total_count, '0);
      end else begin
        want = owed_results.pop_front();
        if (out_data.bin_index !== want.bin_index)
          report_mismatch("bin_index", out_data.bin_index, want.bin_index);
        if (out_data.point_cell !== want.point_cell)
          report_mismatch("point_cell", out_data.point_cell, want.point_cell);
        if (out_data.point_done !== want.point_done)
          report_mismatch("point_done", out_data.point_done, want.point_done);
        if (out_data.cell_count !== want.cell_count)
          report_mismatch("cell_count", out_data.cell_count, want.cell_count);
        if (out_data.total_count !== want.total_count)
          report_mismatch("total_count", out_data.total_count, want.total_count);
      end
    end
  end

  // Watchdog on cycles without any traffic
  always @(posedge clk) begin : watchdog
    if ((start && !busy) || out_valid || cfg_we) begin
      stalled <= 0;
    end else begin
      stalled <= stalled + 1;
      if (stalled >= IDLE_LIMIT) begin
        $display("multidim_histogram_binner_tb: FAIL");
        $finish;
      end
    end
  end

  // Item builders: unused fields carry random noise
  function automatic in_item_t random_item();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[49:0];
  endfunction

  task automatic push_edge(input int unsigned k, input logic [31:0] v);
    in_item_t it;
    it = random_item();
    it.kind = KIND_EDGE;
    it.edge_index = k[3:0];
    it.value = v;
    if (k[3:0] != 0) plan_edge[k[3:0]] = v;
    pending_items.push_back(it);
  endtask

  task automatic push_coord(input logic [31:0] v);
    in_item_t it;
    it = random_item();
    it.kind = KIND_COORD;
    it.value = v;
    pending_items.push_back(it);
  endtask

  task automatic push_read(input int unsigned c);
    in_item_t it;
    it = random_item();
    it.kind = KIND_READ;
    it.cell_index = c[11:0];
    pending_items.push_back(it);
  endtask

  task automatic push_none();
    in_item_t it;
    it = random_item();
    it.kind = KIND_NONE;
    pending_items.push_back(it);
  endtask

  // Coordinates cluster on and around the edges in use, with some far outliers
  function automatic logic [31:0] pick_coord();
    logic [31:0] e, jit;
    e = plan_edge[$urandom_range(1, plan_bins - 1)];
    jit = $urandom_range(0, 65535);
    case ($urandom_range(0, 9))
      0, 1, 2: return e;
      3:       return e - 32'd1;
      4:       return e + 32'd1;
      5, 6:    return e + jit - 32'd32768;
      7:       return ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic load_edges(input edge_shape_t shape);
    logic signed [31:0] v [1:15];
    logic signed [31:0] t;
    int j;
    for (int k = 1; k <= 15; k++) begin
      if (shape == EDGES_NARROW) v[k] = $urandom_range(0, 32'h10_0000) - 32'h8_0000;
      else v[k] = $urandom;
    end
    // insertion sort, signed order
    if (shape != EDGES_SHUFFLED) begin
      for (int k = 2; k <= 15; k++) begin
        t = v[k];
        j = k - 1;
        while (j >= 1 && v[j] > t) begin
          v[j + 1] = v[j];
          j--;
        end
        v[j + 1] = t;
      end
    end
    for (int k = 1; k <= 15; k++) push_edge(k, v[k]);
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || start || owed_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [4:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // One phase: settle, set registers, optionally reload edges, then a random mix
  task automatic run_phase(input logic [4:0] bins_raw, input logic [1:0] dims_raw,
                           input bit reload, input edge_shape_t shape, input idle_t mode);
    int unsigned cells, sel, n_items;
    wait_drained();
    repeat (SETTLE_CYC) @(posedge clk);
    write_reg(CFG_NUM_BINS, bins_raw);
    write_reg(CFG_NUM_DIMS, {3'b000, dims_raw});
    plan_bins = (bins_raw < MIN_BINS) ? MIN_BINS : (bins_raw > MAX_BINS_DEF) ? MAX_BINS_DEF : bins_raw;
    plan_dims = (dims_raw == 0) ? 1 : dims_raw;
    cells = 1;
    for (int d = 0; d < plan_dims; d++) cells = cells * plan_bins;
    idle_mode = mode;
    if (reload) load_edges(shape);
    n_items = $urandom_range(90, 110);
    for (int i = 0; i < n_items; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 74) push_coord(pick_coord());
      else if (sel < 88)
        push_read(($urandom_range(0, 4) == 0) ? $urandom_range(0, CELL_DEPTH - 1)
                                              : $urandom_range(0, cells - 1));
      else if (sel < 94) push_edge($urandom_range(0, 15), pick_coord());
      else push_none();
    end
  endtask

  initial begin : stimulus
    edge_shape_t shape;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at reset settings: 16 bins, 2 dims, edges at -7.0 .. 7.0
    plan_bins = NUM_BINS_RST;
    plan_dims = NUM_DIMS_RST;
    for (int k = 1; k <= 15; k++) push_edge(k, (k - 8) * 65536);
    push_coord(32'h8000_0000);          // most negative: bottom bin
    push_coord(32'h7FFF_FFFF);          // most positive: top bin
    push_coord(-7 * 65536);             // exactly on the first edge
    push_coord(7 * 65536 - 1);          // just under the last edge
    push_coord(32'h0000_0000);          // on a middle edge
    push_coord(32'hFFFF_FFFF);          // just under it
    push_read(15);
    push_read(CELL_DEPTH - 1);
    push_read(0);
    push_none();
    push_edge(0, 32'h1234_5678);        // edge index zero is ignored
    push_coord(32'h0001_8000);          // lone coordinate: point left open over the next phase

    // Fixed settings first: extremes and out-of-range register values
    run_phase(5'd2,  2'd1, 1'b1, EDGES_NARROW,   IDLE_NONE);
    run_phase(5'd16, 2'd3, 1'b1, EDGES_WIDE,     IDLE_FULL);
    run_phase(5'd0,  2'd3, 1'b1, EDGES_SHUFFLED, IDLE_SOME);
    run_phase(5'd31, 2'd0, 1'b1, EDGES_NARROW,   IDLE_FULL);
    run_phase(5'd1,  2'd2, 1'b0, EDGES_NARROW,   IDLE_NONE);
    run_phase(5'd17, 2'd3, 1'b1, EDGES_WIDE,     IDLE_SOME);

    // Random settings, mostly in range, edge tables mostly sorted
    for (int p = 6; p < N_PHASES; p++) begin
      case ($urandom_range(0, 19))
        0, 1, 2:  shape = EDGES_SHUFFLED;
        3, 4, 5, 6, 7, 8, 9, 10: shape = EDGES_WIDE;
        default:  shape = EDGES_NARROW;
      endcase
      run_phase(5'(($urandom_range(0, 3) != 0) ? $urandom_range(2, 16)
                                              : $urandom_range(0, 31)),
                2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), shape,
                idle_t'($urandom_range(0, 2)));
    end

    wait_drained();
    repeat (SETTLE_CYC) @(posedge clk);
    if (n_errors == 0) $display("multidim_histogram_binner_tb: PASS");
    else $display("multidim_histogram_binner_tb: FAIL");
    $finish;
  end

endmodule
